// ===== hdl/quaternion_to_rotation_matrix_macros.svh =====
// assertion macros shared by the rotation matrix block
// needs signals named clk and rst_n in the scope of use
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// plain property checked on every edge out of reset
`define Q2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in the same cycle implies the consequent
`define Q2R_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies the consequent in the next cycle
`define Q2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/q2r_pkg.sv =====
// widths, types and constants of the quaternion to rotation matrix block
// no dependencies
package q2r_pkg;

  localparam int QUAT_W    = 16;             // Q1.14 component
  localparam int CELL_W    = 18;             // Q1.16 matrix entry
  localparam int PROD_W    = 32;             // 16x16 signed product
  localparam int NORM_W    = 33;             // squared norm, up to 2^32
  localparam int NUM_W     = 35;             // signed numerator
  localparam int MAG_W     = 33;             // numerator magnitude, <= norm
  localparam int QUO_BITS  = 17;             // quotient bits, value <= 65536
  localparam int DVS_W     = NORM_W + 1;     // divisor 2N
  localparam int DIV_W     = MAG_W + QUO_BITS + 1;
  localparam int NUM_CELLS = 9;

  localparam logic [QUO_BITS-1:0] ONE_Q16 = QUO_BITS'(65536);

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [CELL_W-1:0] cell_t;

endpackage

// ===== hdl/q2r_if.sv =====
// valid/ready channels for quaternion input and matrix result
// depends on q2r_pkg
interface q2r_in_if;
  logic           valid;
  logic           ready;
  q2r_pkg::quat_t quat_x;
  q2r_pkg::quat_t quat_y;
  q2r_pkg::quat_t quat_z;
  q2r_pkg::quat_t quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2r_out_if;
  logic           valid;
  logic           ready;
  q2r_pkg::cell_t cell_0_0;
  q2r_pkg::cell_t cell_0_1;
  q2r_pkg::cell_t cell_0_2;
  q2r_pkg::cell_t cell_1_0;
  q2r_pkg::cell_t cell_1_1;
  q2r_pkg::cell_t cell_1_2;
  q2r_pkg::cell_t cell_2_0;
  q2r_pkg::cell_t cell_2_1;
  q2r_pkg::cell_t cell_2_2;
  logic           degenerate;

  modport source (output valid, cell_0_0, cell_0_1, cell_0_2, cell_1_0, cell_1_1,
                  cell_1_2, cell_2_0, cell_2_1, cell_2_2, degenerate, input ready);
  modport sink   (input valid, cell_0_0, cell_0_1, cell_0_2, cell_1_0, cell_1_1,
                  cell_1_2, cell_2_0, cell_2_1, cell_2_2, degenerate, output ready);
endinterface

// ===== hdl/quaternion_to_rotation_matrix.sv =====
// quaternion to 3x3 rotation matrix, pipelined with one bit-step divider per stage
// depends on q2r_pkg, q2r_if.sv and quaternion_to_rotation_matrix_macros.svh
//
//   channel   dir  transfer when             payload
//   in_ch     in   valid && ready            quat_x, quat_y, quat_z, quat_w (Q1.14)
//   out_ch    out  valid && ready            cell_r_c (Q1.16) x9, degenerate
//
// one quaternion per cycle when not stalled; stages: products, norm/numerators,
// dividend setup, 17 restoring division steps (one quotient bit each), output.
// the nine cells share the pipeline, each with its own subtract per step.
// reset clears the stage valid bits only.
// a stalled output freezes the whole pipeline; in_ch.ready drops only then.
`include "quaternion_to_rotation_matrix_macros.svh"

module quaternion_to_rotation_matrix (
  input  logic       clk,
  input  logic       rst_n,
  q2r_in_if.sink     in_ch,
  q2r_out_if.source  out_ch
);

  localparam int QB = q2r_pkg::QUO_BITS;
  localparam int NC = q2r_pkg::NUM_CELLS;

  logic en;
  logic out_v_r;

  // pipeline advances unless the result is held
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: products
  logic                                v1_r;
  logic signed [q2r_pkg::PROD_W-1:0]   xx_r, yy_r, zz_r, ww_r;
  logic signed [q2r_pkg::PROD_W-1:0]   xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
    if (en) begin
      xx_r <= in_ch.quat_x * in_ch.quat_x;
      yy_r <= in_ch.quat_y * in_ch.quat_y;
      zz_r <= in_ch.quat_z * in_ch.quat_z;
      ww_r <= in_ch.quat_w * in_ch.quat_w;
      xy_r <= in_ch.quat_x * in_ch.quat_y;
      xz_r <= in_ch.quat_x * in_ch.quat_z;
      yz_r <= in_ch.quat_y * in_ch.quat_z;
      wx_r <= in_ch.quat_w * in_ch.quat_x;
      wy_r <= in_ch.quat_w * in_ch.quat_y;
      wz_r <= in_ch.quat_w * in_ch.quat_z;
    end
  end

  // stage 2: squared norm and signed numerators
  logic                                v2_r;
  logic        [q2r_pkg::NORM_W-1:0]   n2_r;
  logic signed [q2r_pkg::NUM_W-1:0]    num2_r [NC];
  logic signed [q2r_pkg::NUM_W-1:0]    exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;

  always_comb begin
    exx = q2r_pkg::NUM_W'(xx_r);
    eyy = q2r_pkg::NUM_W'(yy_r);
    ezz = q2r_pkg::NUM_W'(zz_r);
    eww = q2r_pkg::NUM_W'(ww_r);
    exy = q2r_pkg::NUM_W'(xy_r);
    exz = q2r_pkg::NUM_W'(xz_r);
    eyz = q2r_pkg::NUM_W'(yz_r);
    ewx = q2r_pkg::NUM_W'(wx_r);
    ewy = q2r_pkg::NUM_W'(wy_r);
    ewz = q2r_pkg::NUM_W'(wz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      n2_r      <= q2r_pkg::NORM_W'(exx + eyy + ezz + eww);
      num2_r[0] <= eww + exx - eyy - ezz;
      num2_r[1] <= (exy + ewz) <<< 1;
      num2_r[2] <= (exz - ewy) <<< 1;
      num2_r[3] <= (exy - ewz) <<< 1;
      num2_r[4] <= eww - exx + eyy - ezz;
      num2_r[5] <= (eyz + ewx) <<< 1;
      num2_r[6] <= (exz + ewy) <<< 1;
      num2_r[7] <= (eyz - ewx) <<< 1;
      num2_r[8] <= eww - exx - eyy + ezz;
    end
  end

  // division pipeline registers, index 0 is the setup stage
  logic                               vd_r  [QB+1];
  logic                               dg_r  [QB+1];
  logic [q2r_pkg::DVS_W-1:0]          dv_r  [QB+1];
  logic [q2r_pkg::DIV_W-1:0]          rem_r [QB+1][NC];
  logic [QB-1:0]                      quo_r [QB+1][NC];
  logic                               neg_r [QB+1][NC];

  // stage 3: magnitude, rounding dividend mag*2^17 + N, divisor 2N
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v2_r;
    end
    if (en) begin
      dg_r[0] <= (n2_r == '0);
      dv_r[0] <= {n2_r, 1'b0};
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_setup
    logic                      neg;
    logic [q2r_pkg::MAG_W-1:0] mag;
    logic signed [q2r_pkg::NUM_W-1:0] negv;
    assign neg  = num2_r[c][q2r_pkg::NUM_W-1];
    assign negv = -num2_r[c];
    assign mag  = neg ? negv[q2r_pkg::MAG_W-1:0] : num2_r[c][q2r_pkg::MAG_W-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[0][c] <= neg;
        quo_r[0][c] <= '0;
        rem_r[0][c] <= {1'b0, mag, {QB{1'b0}}}
                       + q2r_pkg::DIV_W'(n2_r);
      end
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [q2r_pkg::DIV_W-1:0] trial;
    assign trial = q2r_pkg::DIV_W'(dv_r[k]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (en) begin
        vd_r[k+1] <= vd_r[k];
      end
      if (en) begin
        dg_r[k+1] <= dg_r[k];
        dv_r[k+1] <= dv_r[k];
      end
    end

    for (genvar c = 0; c < NC; c++) begin : g_cell
      logic take;
      assign take = (rem_r[k][c] >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          neg_r[k+1][c] <= neg_r[k][c];
          rem_r[k+1][c] <= take ? rem_r[k][c] - trial : rem_r[k][c];
          quo_r[k+1][c] <= quo_r[k][c] | (QB'(take) << SH);
        end
      end
    end
  end

  // output stage: clamp, sign, identity for a zero norm
  q2r_pkg::cell_t cell_nxt [NC];
  q2r_pkg::cell_t cell_r   [NC];
  logic           dg_out_r;

  for (genvar c = 0; c < NC; c++) begin : g_out
    logic [QB-1:0]  qc;
    q2r_pkg::cell_t mag_c;
    assign qc    = (quo_r[QB][c] > q2r_pkg::ONE_Q16) ? q2r_pkg::ONE_Q16 : quo_r[QB][c];
    assign mag_c = q2r_pkg::cell_t'({1'b0, qc});
    always_comb begin
      if (dg_r[QB]) begin
        cell_nxt[c] = (c % 4 == 0) ? q2r_pkg::cell_t'({1'b0, q2r_pkg::ONE_Q16}) : '0;
      end else begin
        cell_nxt[c] = neg_r[QB][c] ? -mag_c : mag_c;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cell_r[c] <= cell_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vd_r[QB];
    end
    if (en) begin
      dg_out_r <= dg_r[QB];
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.degenerate = dg_out_r;
  assign out_ch.cell_0_0   = cell_r[0];
  assign out_ch.cell_0_1   = cell_r[1];
  assign out_ch.cell_0_2   = cell_r[2];
  assign out_ch.cell_1_0   = cell_r[3];
  assign out_ch.cell_1_1   = cell_r[4];
  assign out_ch.cell_1_2   = cell_r[5];
  assign out_ch.cell_2_0   = cell_r[6];
  assign out_ch.cell_2_1   = cell_r[7];
  assign out_ch.cell_2_2   = cell_r[8];

  // checks
  `Q2R_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, v1_r, "accepted item not in stage 1")
  `Q2R_ASSERT_IMP(a_ready_stall, !in_ch.ready, out_v_r && !out_ch.ready, "input stalled without output stall")
  `Q2R_ASSERT_IMP(a_degen_identity, out_v_r && dg_out_r, (cell_r[1] == '0) && (cell_r[3] == '0) && (cell_r[0] == cell_r[8]), "degenerate result not identity")
  `Q2R_ASSERT_IMP(a_cell_range, out_v_r, (cell_r[0] <= 18'sd65536) && (cell_r[0] >= -18'sd65536), "diagonal cell out of range")

endmodule
